### hw/rtl/bpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpd_pkg: shared types and constants of the balance PD controller
// Register indexes, arm codes, sequencer states and reset values.
// ----------------------------------------------------------------------------
package bpd_pkg;

  localparam int DATA_WIDTH_DEF = 24;
  localparam int GAIN_W         = 16;
  localparam int GAIN_FRAC      = 8;
  localparam int ALPHA_FRAC     = 16;
  localparam int CFG_ADDR_W     = 3;
  localparam int ARM_W          = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_GAIN   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RATE_GAIN    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OUTPUT_LIMIT = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FILTER_ALPHA = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TILT_LIMIT   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_RATE_LIMIT   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_STEER_LIMIT  = 3'd6;

  localparam logic [ARM_W-1:0] ARM_KEEP   = 2'd0;
  localparam logic [ARM_W-1:0] ARM_ON     = 2'd1;
  localparam logic [ARM_W-1:0] ARM_OFF    = 2'd2;

  localparam logic [GAIN_W-1:0] ANGLE_GAIN_RST   = 16'd5120;
  localparam logic [GAIN_W-1:0] RATE_GAIN_RST    = 16'd128;
  localparam logic [GAIN_W-1:0] FILTER_ALPHA_RST = 16'd13107;
  localparam logic [31:0]       OUTPUT_LIMIT_RST = 32'd768000;
  localparam logic [31:0]       TILT_LIMIT_RST   = 32'd7680;
  localparam logic [31:0]       RATE_LIMIT_RST   = 32'd128000;
  localparam logic [31:0]       STEER_LIMIT_RST  = 32'd128000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMA,
    ST_TRIP,
    ST_PROP,
    ST_DERIV,
    ST_MIX
  } bpd_state_t;

endpackage

`default_nettype wire

### hw/rtl/bpd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpd_if: channel interfaces of the balance PD controller
// Valid/ready channels for control ticks and controller results.
// ----------------------------------------------------------------------------
interface bpd_in_if #(
  parameter int DATA_WIDTH = bpd_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] tilt_meas;
  logic signed [DATA_WIDTH-1:0] pitch_rate;
  logic signed [DATA_WIDTH-1:0] tilt_setpt;
  logic signed [DATA_WIDTH-1:0] steer_offset;
  logic [bpd_pkg::ARM_W-1:0]    arm_cmd;

  modport source (
    output valid, tilt_meas, pitch_rate, tilt_setpt, steer_offset, arm_cmd,
    input  ready
  );
  modport sink (
    input  valid, tilt_meas, pitch_rate, tilt_setpt, steer_offset, arm_cmd,
    output ready
  );
endinterface

interface bpd_out_if #(
  parameter int DATA_WIDTH = bpd_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive_out;
  logic signed [DATA_WIDTH:0]   speed_left;
  logic signed [DATA_WIDTH:0]   speed_right;
  logic                         active_now;
  logic                         tripped;

  modport source (
    output valid, drive_out, speed_left, speed_right, active_now, tripped,
    input  ready
  );
  modport sink (
    input  valid, drive_out, speed_left, speed_right, active_now, tripped,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/bpd_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpd_mul: shared signed multiplier
// One registered signed product per cycle, reused by the sequencer.
// ----------------------------------------------------------------------------
module bpd_mul #(
  parameter int A_W = 25,
  parameter int B_W = 17
) (
  input  wire                        clk,
  input  wire  logic signed [A_W-1:0] mul_a,
  input  wire  logic signed [B_W-1:0] mul_b,
  output logic signed [A_W+B_W-1:0]   prod_r
);

  logic signed [A_W+B_W-1:0] prod_nxt;

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/balance_pd_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// balance_pd_controller: PD balance loop with tilt and rate cutoff
// Each transaction on in_ch is one control tick and yields one transaction
// on out_ch. The user writes gains, limits and the gyro filter coefficient
// on the cfg_ port (cfg_we, cfg_addr, cfg_wdata) only while the block is
// idle; the block itself does not enforce this. An inactive tick goes from
// IDLE straight to MIX, a trip tick passes EMA and TRIP first, an active
// tick EMA, TRIP, PROP and DERIV. The block takes one tick at a time;
// in_ch.ready is high only in the idle state, so no tick is accepted until
// the last one has left MIX. An active tick makes three passes through the
// single shared multiplier (filter update, proportional term, derivative
// term). The result sits in an output register, so the next tick is
// accepted while out_ch waits; a stalled receiver holds the result and the
// sequencer waits at the final step until the register frees.
// Synchronous active-low reset loads the register defaults, disarms the
// controller, clears the gyro filter and drops out_ch.valid.
// ----------------------------------------------------------------------------
module balance_pd_controller #(
  parameter int DATA_WIDTH = bpd_pkg::DATA_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  bpd_in_if.sink                        in_ch,
  bpd_out_if.source                     out_ch,
  input  wire                           cfg_we,
  input  wire [bpd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire [((bpd_pkg::GAIN_W > DATA_WIDTH-1) ?
                bpd_pkg::GAIN_W : DATA_WIDTH-1)-1:0] cfg_wdata
);
  import bpd_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int EW   = DW + 1;
  localparam int LW   = DW - 1;
  localparam int MB_W = GAIN_W + 1;
  localparam int PW   = EW + MB_W;
  localparam int AW   = PW + 1;
  localparam int SW   = PW - ALPHA_FRAC;

  // configuration
  logic [GAIN_W-1:0] kp_r, kd_r, alpha_r;
  logic [LW-1:0]     out_lim_r, tilt_lim_r, rate_lim_r, steer_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= ANGLE_GAIN_RST;
      kd_r        <= RATE_GAIN_RST;
      alpha_r     <= FILTER_ALPHA_RST;
      out_lim_r   <= LW'(OUTPUT_LIMIT_RST);
      tilt_lim_r  <= LW'(TILT_LIMIT_RST);
      rate_lim_r  <= LW'(RATE_LIMIT_RST);
      steer_lim_r <= LW'(STEER_LIMIT_RST);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ANGLE_GAIN:   kp_r        <= cfg_wdata[GAIN_W-1:0];
        REG_RATE_GAIN:    kd_r        <= cfg_wdata[GAIN_W-1:0];
        REG_OUTPUT_LIMIT: out_lim_r   <= cfg_wdata[LW-1:0];
        REG_FILTER_ALPHA: alpha_r     <= cfg_wdata[GAIN_W-1:0];
        REG_TILT_LIMIT:   tilt_lim_r  <= cfg_wdata[LW-1:0];
        REG_RATE_LIMIT:   rate_lim_r  <= cfg_wdata[LW-1:0];
        REG_STEER_LIMIT:  steer_lim_r <= cfg_wdata[LW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath state
  bpd_state_t              state_r, state_nxt;
  logic                    en_r, en_nxt;
  logic signed [DW-1:0]    rf_r, rf_nxt;
  logic signed [EW-1:0]    diff_r, diff_nxt;
  logic signed [EW-1:0]    err_r, err_nxt;
  logic signed [DW-1:0]    steer_r, steer_nxt;
  logic signed [PW-1:0]    acc_r, acc_nxt;
  logic                    zero_r, zero_nxt;
  logic                    trip_r, trip_nxt;

  logic                    oval_r, oval_nxt;
  logic signed [DW-1:0]    obal_r, obal_nxt;
  logic signed [DW:0]      oleft_r, oleft_nxt;
  logic signed [DW:0]      oright_r, oright_nxt;
  logic                    oact_r, oact_nxt;
  logic                    otrip_r, otrip_nxt;

  // shared multiplier
  logic signed [EW-1:0]    mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [PW-1:0]    prod_r;

  bpd_mul #(
    .A_W (EW),
    .B_W (MB_W)
  ) u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // hold the derivative operands through the final step
  always_comb begin
    unique case (state_r)
      ST_EMA: begin
        mul_a = diff_r;
        mul_b = signed'({1'b0, alpha_r});
      end
      ST_PROP: begin
        mul_a = err_r;
        mul_b = signed'({1'b0, kp_r});
      end
      ST_DERIV, ST_MIX: begin
        mul_a = {rf_r[DW-1], rf_r};
        mul_b = signed'({1'b0, kd_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // arithmetic around the multiplier
  logic signed [SW-1:0] ema_step;
  logic signed [SW-1:0] rf_sum;
  logic signed [DW-1:0] rf_new;
  logic signed [EW-1:0] rf_ext, tilt_ext, rate_ext;
  logic                 trip_hit;
  logic signed [AW-1:0] pd, pd_sh, olim, bal_w;
  logic signed [DW-1:0] slim, st;
  logic signed [DW-1:0] bal;
  logic                 in_hs, out_free;
  logic                 en_cmd;

  assign ema_step = prod_r[PW-1:ALPHA_FRAC];
  assign rf_sum   = SW'(rf_r) + ema_step;
  assign rf_new   = rf_sum[DW-1:0];
  assign rf_ext   = {rf_new[DW-1], rf_new};
  assign tilt_ext = signed'({2'b00, tilt_lim_r});
  assign rate_ext = signed'({2'b00, rate_lim_r});
  assign trip_hit = (err_r > tilt_ext) || (err_r < -tilt_ext) ||
                    (rf_ext > rate_ext) || (rf_ext < -rate_ext);

  assign pd    = {acc_r[PW-1], acc_r} - {prod_r[PW-1], prod_r};
  assign pd_sh = pd >>> GAIN_FRAC;
  assign olim  = signed'({{(AW-LW){1'b0}}, out_lim_r});
  assign bal_w = (pd_sh > olim) ? olim : ((pd_sh < -olim) ? -olim : pd_sh);
  assign bal   = bal_w[DW-1:0];

  assign slim = signed'({1'b0, steer_lim_r});
  assign st   = (steer_r > slim) ? slim : ((steer_r < -slim) ? -slim : steer_r);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_hs       = in_ch.valid && in_ch.ready;
  assign out_free    = !oval_r || out_ch.ready;

  always_comb begin
    unique case (in_ch.arm_cmd)
      ARM_ON:  en_cmd = 1'b1;
      ARM_OFF: en_cmd = 1'b0;
      default: en_cmd = en_r;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    en_nxt     = en_r;
    rf_nxt     = rf_r;
    diff_nxt   = diff_r;
    err_nxt    = err_r;
    steer_nxt  = steer_r;
    acc_nxt    = acc_r;
    zero_nxt   = zero_r;
    trip_nxt   = trip_r;
    oval_nxt   = oval_r && !out_ch.ready;
    obal_nxt   = obal_r;
    oleft_nxt  = oleft_r;
    oright_nxt = oright_r;
    oact_nxt   = oact_r;
    otrip_nxt  = otrip_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_hs) begin
          en_nxt    = en_cmd;
          diff_nxt  = EW'(in_ch.pitch_rate) - EW'(rf_r);
          err_nxt   = EW'(in_ch.tilt_setpt) - EW'(in_ch.tilt_meas);
          steer_nxt = in_ch.steer_offset;
          trip_nxt  = 1'b0;
          zero_nxt  = !en_cmd;
          state_nxt = en_cmd ? ST_EMA : ST_MIX;
        end
      end
      ST_EMA: begin
        state_nxt = ST_TRIP;
      end
      ST_TRIP: begin
        if (trip_hit) begin
          en_nxt    = 1'b0;
          rf_nxt    = '0;
          trip_nxt  = 1'b1;
          zero_nxt  = 1'b1;
          state_nxt = ST_MIX;
        end else begin
          rf_nxt    = rf_new;
          state_nxt = ST_PROP;
        end
      end
      ST_PROP: begin
        state_nxt = ST_DERIV;
      end
      ST_DERIV: begin
        acc_nxt   = prod_r;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        if (out_free) begin
          oval_nxt  = 1'b1;
          oact_nxt  = en_r;
          otrip_nxt = trip_r;
          if (zero_r) begin
            obal_nxt   = '0;
            oleft_nxt  = '0;
            oright_nxt = '0;
          end else begin
            obal_nxt   = bal;
            oleft_nxt  = {bal[DW-1], bal} + {st[DW-1], st};
            oright_nxt = {bal[DW-1], bal} - {st[DW-1], st};
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      en_r    <= 1'b0;
      rf_r    <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      en_r    <= en_nxt;
      rf_r    <= rf_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r   <= diff_nxt;
    err_r    <= err_nxt;
    steer_r  <= steer_nxt;
    acc_r    <= acc_nxt;
    zero_r   <= zero_nxt;
    trip_r   <= trip_nxt;
    obal_r   <= obal_nxt;
    oleft_r  <= oleft_nxt;
    oright_r <= oright_nxt;
    oact_r   <= oact_nxt;
    otrip_r  <= otrip_nxt;
  end

  assign out_ch.valid       = oval_r;
  assign out_ch.drive_out   = obal_r;
  assign out_ch.speed_left  = oleft_r;
  assign out_ch.speed_right = oright_r;
  assign out_ch.active_now  = oact_r;
  assign out_ch.tripped     = otrip_r;

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the balance PD controller
// Drives a directed run of control ticks and then random bursts under
// several gain and limit settings, stalls the result side on varying
// patterns, and compares every result field against an internal
// fixed-point prediction of the loop.
module tb;
  import bpd_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int DW = DATA_WIDTH_DEF;
  localparam int LIM_W = DW - 1;
  localparam longint SIG_MAX = 8388607;
  localparam longint SIG_MIN = -8388608;
  localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;
  localparam logic [ARM_W-1:0] ARM_SPARE = 2'd3;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 153;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic signed [DW-1:0] tilt;
    logic signed [DW-1:0] gyro;
    logic signed [DW-1:0] target;
    logic signed [DW-1:0] steer;
    logic [ARM_W-1:0]     arm;
  } tick_t;

  typedef struct {
    logic signed [DW-1:0] balance;
    logic signed [DW:0]   left;
    logic signed [DW:0]   right;
    logic                 active;
    logic                 tripped;
  } result_t;

  class balance_checker;
    logic [GAIN_W-1:0] angle_gain;
    logic [GAIN_W-1:0] rate_gain;
    logic [GAIN_W-1:0] filter_alpha;
    logic [LIM_W-1:0]  output_limit;
    logic [LIM_W-1:0]  tilt_limit;
    logic [LIM_W-1:0]  rate_limit;
    logic [LIM_W-1:0]  steer_limit;
    longint            rate_filt;
    bit                armed;
    result_t           pending_results[$];
    int                mismatches;
    int                ticks;
    int                armed_results;
    int                trips;

    function new();
      angle_gain   = ANGLE_GAIN_RST;
      rate_gain    = RATE_GAIN_RST;
      filter_alpha = FILTER_ALPHA_RST;
      output_limit = OUTPUT_LIMIT_RST[LIM_W-1:0];
      tilt_limit   = TILT_LIMIT_RST[LIM_W-1:0];
      rate_limit   = RATE_LIMIT_RST[LIM_W-1:0];
      steer_limit  = STEER_LIMIT_RST[LIM_W-1:0];
      rate_filt    = 0;
      armed        = 0;
      mismatches   = 0;
      ticks        = 0;
      armed_results = 0;
      trips        = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [LIM_W-1:0] val);
      case (idx)
        REG_ANGLE_GAIN:   angle_gain   = val[GAIN_W-1:0];
        REG_RATE_GAIN:    rate_gain    = val[GAIN_W-1:0];
        REG_OUTPUT_LIMIT: output_limit = val;
        REG_FILTER_ALPHA: filter_alpha = val[GAIN_W-1:0];
        REG_TILT_LIMIT:   tilt_limit   = val;
        REG_RATE_LIMIT:   rate_limit   = val;
        REG_STEER_LIMIT:  steer_limit  = val;
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void take_tick(tick_t t);
      result_t r;
      longint err;
      longint pd;
      longint bal;
      longint st;
      r.balance = '0;
      r.left    = '0;
      r.right   = '0;
      r.tripped = 1'b0;
      ticks++;
      if (t.arm == ARM_ON) begin
        armed = 1;
      end else if (t.arm == ARM_OFF) begin
        armed = 0;
      end
      if (armed) begin
        rate_filt += ((longint'(t.gyro) - rate_filt) * longint'(filter_alpha)) >>> ALPHA_FRAC;
        err = longint'(t.target) - longint'(t.tilt);
        if (err > longint'(tilt_limit) || err < -longint'(tilt_limit) ||
            rate_filt > longint'(rate_limit) || rate_filt < -longint'(rate_limit)) begin
          armed = 0;
          rate_filt = 0;
          r.tripped = 1'b1;
          trips++;
        end else begin
          pd = longint'(angle_gain) * err - longint'(rate_gain) * rate_filt;
          bal = clamp(pd >>> GAIN_FRAC, longint'(output_limit));
          st = clamp(longint'(t.steer), longint'(steer_limit));
          r.balance = DW'(bal);
          r.left = (DW+1)'(bal + st);
          r.right = (DW+1)'(bal - st);
          armed_results++;
        end
      end
      r.active = armed;
      pending_results.push_back(r);
    endfunction

    function void report(string field, longint want, longint got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no tick pending, drive_out %0d", $time,
                 longint'(got.balance));
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.balance !== want.balance)
        report("drive_out", longint'(want.balance), longint'(got.balance));
      if (got.left !== want.left)
        report("speed_left", longint'(want.left), longint'(got.left));
      if (got.right !== want.right)
        report("speed_right", longint'(want.right), longint'(got.right));
      if (got.active !== want.active)
        report("active_now", longint'(want.active), longint'(got.active));
      if (got.tripped !== want.tripped)
        report("tripped", longint'(want.tripped), longint'(got.tripped));
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [LIM_W-1:0] cfg_wdata;
  int               rx_mode;
  int               rx_cycle;
  int               hold_left;
  bit               hold_req;
  balance_checker   sb;

  bpd_in_if  in_ch ();
  bpd_out_if out_ch ();

  balance_pd_controller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // receiver: long hold on request, otherwise the current stall pattern
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        2: out_ch.ready <= ($urandom_range(0, 9) != 0);
        default: out_ch.ready <= ((rx_cycle % 7) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    result_t got;
    tick_t   t;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        t.tilt   = in_ch.tilt_meas;
        t.gyro   = in_ch.pitch_rate;
        t.target = in_ch.tilt_setpt;
        t.steer  = in_ch.steer_offset;
        t.arm    = in_ch.arm_cmd;
        sb.take_tick(t);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.balance = out_ch.drive_out;
        got.left    = out_ch.speed_left;
        got.right   = out_ch.speed_right;
        got.active  = out_ch.active_now;
        got.tripped = out_ch.tripped;
        sb.check_result(got);
      end
    end
  end

  initial begin
    #(CLK_PERIOD * 500000);
    $display("%0t: timeout, %0d results still pending", $time, sb.pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic tick_t mk_tick(longint tilt, longint gyro, longint target,
                                    longint steer, logic [ARM_W-1:0] arm);
    tick_t t;
    t.tilt   = DW'(tilt);
    t.gyro   = DW'(gyro);
    t.target = DW'(target);
    t.steer  = DW'(steer);
    t.arm    = arm;
    return t;
  endfunction

  function automatic longint rand_span(longint mag);
    if (mag > SIG_MAX) mag = SIG_MAX;
    return longint'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  function automatic longint pick_edge(longint lim);
    case ($urandom_range(0, 6))
      0: return SIG_MIN;
      1: return SIG_MAX;
      2: return 0;
      3: return 1;
      4: return -1;
      5: return lim;
      default: return -lim;
    endcase
  endfunction

  function automatic logic [ARM_W-1:0] random_arm();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return ARM_ON;
    if (r < 13) return ARM_OFF;
    if (r < 15) return ARM_SPARE;
    return ARM_KEEP;
  endfunction

  function automatic tick_t random_tick();
    tick_t  t;
    int unsigned kind;
    longint tl;
    longint rl;
    longint sl;
    tl = longint'(sb.tilt_limit);
    rl = longint'(sb.rate_limit);
    sl = longint'(sb.steer_limit);
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      t.tilt   = DW'(rand_span(4000000));
      t.target = DW'(longint'(t.tilt) +
                     rand_span((tl + 3 > 4000000) ? 4000000 : tl + 3));
      t.gyro   = DW'(rand_span(rl + rl / 8 + 3));
      t.steer  = DW'(rand_span(2 * sl + 3));
    end else if (kind < 90) begin
      t.tilt   = DW'($urandom());
      t.gyro   = DW'($urandom());
      t.target = DW'($urandom());
      t.steer  = DW'($urandom());
    end else begin
      t.tilt   = DW'(pick_edge(tl));
      t.target = DW'(pick_edge(tl));
      t.gyro   = DW'(pick_edge(rl));
      t.steer  = DW'(pick_edge(sl));
    end
    t.arm = random_arm();
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    in_ch.valid        <= 1'b1;
    in_ch.tilt_meas    <= t.tilt;
    in_ch.pitch_rate   <= t.gyro;
    in_ch.tilt_setpt   <= t.target;
    in_ch.steer_offset <= t.steer;
    in_ch.arm_cmd      <= t.arm;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [LIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic [GAIN_W-1:0] ag, logic [GAIN_W-1:0] rg,
                           logic [LIM_W-1:0] olim, logic [GAIN_W-1:0] alpha,
                           logic [LIM_W-1:0] tlim, logic [LIM_W-1:0] rlim,
                           logic [LIM_W-1:0] slim);
    logic [LIM_W-GAIN_W-1:0] junk;
    junk = (LIM_W-GAIN_W)'($urandom());
    write_reg(REG_ANGLE_GAIN, {junk, ag});
    junk = (LIM_W-GAIN_W)'($urandom());
    write_reg(REG_RATE_GAIN, {junk, rg});
    write_reg(REG_OUTPUT_LIMIT, olim);
    junk = (LIM_W-GAIN_W)'($urandom());
    write_reg(REG_FILTER_ALPHA, {junk, alpha});
    write_reg(REG_TILT_LIMIT, tlim);
    write_reg(REG_RATE_LIMIT, rlim);
    write_reg(REG_STEER_LIMIT, slim);
    write_reg(REG_NONE, LIM_W'($urandom()));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [LIM_W-1:0] random_limit();
    case ($urandom_range(0, 3))
      0: return LIM_W'($urandom_range(0, 16));
      1: return LIM_W'($urandom_range(0, 300000));
      2: return LIM_W'($urandom_range(0, SIG_MAX));
      default: return LIM_W'(SIG_MAX);
    endcase
  endfunction

  task automatic wait_idle();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_random(int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_tick(random_tick());
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_tick(mk_tick(SIG_MAX, SIG_MIN, SIG_MIN, SIG_MAX, ARM_KEEP));
    send_tick(mk_tick(0, 0, 0, 0, ARM_ON));
    send_tick(mk_tick(0, 1000, 0, 500, ARM_ON));
    send_tick(mk_tick(0, 0, 7680, 0, ARM_KEEP));
    send_tick(mk_tick(7680, 0, 0, SIG_MIN, ARM_KEEP));
    send_tick(mk_tick(100, -300, 200, SIG_MAX, ARM_SPARE));
    send_tick(mk_tick(0, 0, 7681, 0, ARM_KEEP));
    send_tick(mk_tick(0, 0, 0, 0, ARM_KEEP));
    send_tick(mk_tick(SIG_MIN, 0, SIG_MAX, 0, ARM_ON));
    send_tick(mk_tick(0, SIG_MAX, 0, 0, ARM_ON));
    send_tick(mk_tick(0, SIG_MIN, 0, 0, ARM_ON));
    send_tick(mk_tick(0, 0, 0, 0, ARM_SPARE));
    send_tick(mk_tick(-5000, 40000, 2000, 128000, ARM_ON));
    send_tick(mk_tick(-5000, -40000, 2000, -128001, ARM_KEEP));
    send_tick(mk_tick(SIG_MAX, SIG_MAX, SIG_MAX, SIG_MAX, ARM_KEEP));
    send_tick(mk_tick(0, 0, 0, 0, ARM_OFF));
    send_tick(mk_tick(1, 2, 3, 4, ARM_KEEP));
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    rx_mode   = 0;
    rx_cycle  = 0;
    hold_left = 0;
    hold_req  = 0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_ANGLE_GAIN;
    cfg_wdata = '0;
    in_ch.valid        = 1'b0;
    in_ch.tilt_meas    = '0;
    in_ch.pitch_rate   = '0;
    in_ch.tilt_setpt   = '0;
    in_ch.steer_offset = '0;
    in_ch.arm_cmd      = ARM_KEEP;
    out_ch.ready       = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: configure(16'hFFFF, 16'hFFFF, LIM_W'(SIG_MAX), 16'hFFFF, LIM_W'(SIG_MAX),
                       LIM_W'(SIG_MAX), LIM_W'(SIG_MAX));
          2: configure('0, '0, '0, '0, '0, '0, '0);
          3: configure(ANGLE_GAIN_RST, RATE_GAIN_RST, LIM_W'($urandom_range(0, 2000)),
                       FILTER_ALPHA_RST, TILT_LIMIT_RST[LIM_W-1:0],
                       RATE_LIMIT_RST[LIM_W-1:0], LIM_W'($urandom_range(0, 2000)));
          default: configure(GAIN_W'($urandom()), GAIN_W'($urandom()), random_limit(),
                             GAIN_W'($urandom()), random_limit(), random_limit(),
                             random_limit());
        endcase
      end
      rx_mode = p % 4;
      if (p == 1 || p == 6) hold_req = 1;
      run_random(ITEMS_PER_PHASE);
    end

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d control ticks over %0d register settings: %0d armed outputs, %0d trips.",
             sb.ticks, PHASES, sb.armed_results, sb.trips);
    $display("Receiver ran always-ready, random, sparse and periodic stalls plus long holds.");
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches,
               sb.pending_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### balance_pd_controller.f
hw/rtl/bpd_pkg.sv
hw/rtl/bpd_if.sv
hw/rtl/bpd_mul.sv
hw/rtl/balance_pd_controller.sv
dv/tb.sv
